### design/drwps_pkg.sv
// Shared types and constants for the dyadic rank-weighted prefix sum block.
// Field widths, node-entry tag size and result queue sizing.
// No dependencies.
package drwps_pkg;

    localparam int RANK_W      = 11;
    localparam int WEIGHT_W    = 32;
    localparam int SUM_W       = 48;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // Set tag stored with every node; a node whose tag differs from the
    // item's tag reads as zero.
    localparam int                EPOCH_W   = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

    // Result queue: depth bounds the items launched into the tree but not yet delivered.
    localparam int OFIFO_AW    = 5;
    localparam int OFIFO_DEPTH = 1 << OFIFO_AW;
    localparam int OCNT_W      = OFIFO_AW + 1;

    // Item payload handed from one level cell to the next.
    typedef struct packed {
        logic [EPOCH_W-1:0]  epoch;
        logic [WEIGHT_W-1:0] weight;
        logic [SUM_W-1:0]    acc;
    } item_t;

    // Stored tree node.
    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [SUM_W-1:0]   sum;
    } node_t;

endpackage

### design/drwps_cell.sv
// One tree level: a node bank with two registered read ports and one write
// port, a read stage and an update stage. Passes the item to the next level.
// Depends on drwps_pkg.
module drwps_cell #(
    parameter int LEVELS = 10,
    parameter int LEVEL  = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 sweep_en,
    input  logic [LEVELS-1:0]    sweep_addr,
    input  logic                 in_valid,
    input  logic [LEVELS-1:0]    in_r1,
    input  drwps_pkg::item_t     in_item,
    output logic                 out_valid,
    output logic [LEVELS-1:0]    out_r1,
    output drwps_pkg::item_t     out_item
);
    import drwps_pkg::*;

    localparam int AW    = LEVELS - LEVEL;
    localparam int DEPTH = 1 << AW;

    node_t             bank [DEPTH];
    node_t             q_rd_reg;
    node_t             i_rd_reg;
    logic              st_valid_reg;
    logic [LEVELS-1:0] st_r1_reg;
    item_t             st_item_reg;
    logic              out_valid_reg;
    logic [LEVELS-1:0] out_r1_reg;
    item_t             out_item_reg;

    logic [AW-1:0]    i_addr;
    logic [AW-1:0]    q_addr;
    logic [AW-1:0]    st_i_addr;
    logic [SUM_W-1:0] q_sum;
    logic [SUM_W-1:0] i_sum;
    logic [SUM_W-1:0] w_ext;
    logic [SUM_W-1:0] acc_next;
    node_t            node_next;

    // Insert node is rank-1 shifted down by the level; the query node is the
    // one just left of it, used only when this level's bit is set.
    assign i_addr    = in_r1[LEVELS-1:LEVEL];
    assign q_addr    = i_addr & ~AW'(1);
    assign st_i_addr = st_r1_reg[LEVELS-1:LEVEL];

    always_comb begin
        q_sum = (q_rd_reg.tag == st_item_reg.epoch) ? q_rd_reg.sum : '0;
        i_sum = (i_rd_reg.tag == st_item_reg.epoch) ? i_rd_reg.sum : '0;
        w_ext = {{(SUM_W - WEIGHT_W){st_item_reg.weight[WEIGHT_W-1]}}, st_item_reg.weight};
        acc_next       = st_item_reg.acc + (st_r1_reg[LEVEL] ? q_sum : '0);
        node_next.tag  = st_item_reg.epoch;
        node_next.sum  = i_sum + w_ext;
    end

    always_ff @(posedge aclk) begin
        if (sweep_en) begin
            bank[sweep_addr[AW-1:0]] <= '0;
        end else if (st_valid_reg) begin
            bank[st_i_addr] <= node_next;
        end
        if (in_valid) begin
            q_rd_reg <= bank[q_addr];
            i_rd_reg <= bank[i_addr];
        end
    end

    always_ff @(posedge aclk) begin
        st_r1_reg    <= in_r1;
        st_item_reg  <= in_item;
        out_r1_reg   <= st_r1_reg;
        out_item_reg <= '{epoch: st_item_reg.epoch, weight: st_item_reg.weight,
                          acc: acc_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st_valid_reg  <= in_valid;
            out_valid_reg <= st_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_r1    = out_r1_reg;
    assign out_item  = out_item_reg;

endmodule

### design/drwps_ofifo.sv
// Result queue with a registered head: takes finished sums from the last
// level and presents them on the output channel.
// Depends on drwps_pkg.
module drwps_ofifo (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push_valid,
    input  logic [drwps_pkg::SUM_W-1:0] push_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [drwps_pkg::SUM_W-1:0] out_data
);
    import drwps_pkg::*;

    logic [SUM_W-1:0]    fifo_mem [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0] wr_ptr_reg;
    logic [OFIFO_AW-1:0] rd_ptr_reg;
    logic [OCNT_W-1:0]   cnt_reg;
    logic                out_valid_reg;
    logic [SUM_W-1:0]    out_data_reg;
    logic                load;

    // Refill the head whenever it is empty or being taken.
    assign load = (cnt_reg != '0) && (!out_valid_reg || out_ready);

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
        if (load) begin
            out_data_reg <= fifo_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (push_valid) begin
                wr_ptr_reg <= wr_ptr_reg + OFIFO_AW'(1);
            end
            if (load) begin
                rd_ptr_reg <= rd_ptr_reg + OFIFO_AW'(1);
            end
            cnt_reg <= cnt_reg + OCNT_W'(push_valid) - OCNT_W'(load);
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### design/dyadic_rank_weighted_prefix_sum_top.sv
// Dyadic rank-weighted prefix sum. Each input transfer carries a rank and a
// signed weight; the result is the sum of the weights of earlier items of the
// current set with a smaller rank. A set starts at any item flagged first.
// The tree is a row of LEVELS cells, one per level, each with its own node
// bank; in each cell an item has its bank read, then its update and write
// back. The block never launches items in adjacent cycles, because of the
// read-modify-write of each level bank. Every node carries an 8-bit set tag
// instead of being cleared at a set start; after reset, and before every
// 256th set start, the block drains the row and runs a clearing pass over
// all 2^LEVELS node addresses during which no item is launched. Up to 32
// results may wait on the output side.
// Depends on drwps_pkg, drwps_cell and drwps_ofifo.
module dyadic_rank_weighted_prefix_sum_top #(
    parameter int LEVELS = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [drwps_pkg::IN_TDATA_W-1:0]  s_tdata,  // rank[10:0], weight[42:11]
    input  logic                              s_tuser,  // first
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [drwps_pkg::OUT_TDATA_W-1:0] m_tdata   // partial_sum[47:0]
);
    import drwps_pkg::*;

    localparam int RCW = (LEVELS + 1 > RANK_W) ? LEVELS + 1 : RANK_W;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_RUN,
        ST_DRAIN
    } ctl_state_t;

    ctl_state_t          state_reg;
    logic [LEVELS-1:0]   sweep_cnt_reg;
    logic [EPOCH_W-1:0]  epoch_reg;
    logic                gap_reg;
    logic [OCNT_W-1:0]   outstanding_reg;
    logic [OCNT_W-1:0]   inflight_reg;
    logic                hold_valid_reg;
    logic                hold_first_reg;
    logic [RANK_W-1:0]   hold_rank_reg;
    logic [WEIGHT_W-1:0] hold_weight_reg;

    logic              s_accept;
    logic              m_accept;
    logic              launch;
    logic [RCW-1:0]    rank_x;
    logic [LEVELS-1:0] launch_r1;
    item_t             launch_item;

    logic              chain_valid [LEVELS+1];
    logic [LEVELS-1:0] chain_r1    [LEVELS+1];
    item_t             chain_item  [LEVELS+1];

    // A set start that would wrap the tag waits for drain and a clearing pass.
    assign launch = (state_reg == ST_RUN) && hold_valid_reg && !gap_reg
                 && (outstanding_reg < OCNT_W'(OFIFO_DEPTH))
                 && !(hold_first_reg && (epoch_reg == EPOCH_MAX));

    assign s_tready = !hold_valid_reg || launch;
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;

    // Clamp rank into 1..2^LEVELS, then take rank-1.
    always_comb begin
        rank_x = RCW'(hold_rank_reg);
        if (rank_x == '0) begin
            launch_r1 = '0;
        end else if (rank_x > (RCW'(1) << LEVELS)) begin
            launch_r1 = '1;
        end else begin
            launch_r1 = LEVELS'(rank_x - RCW'(1));
        end
        launch_item.epoch  = hold_first_reg ? epoch_reg + EPOCH_W'(1) : epoch_reg;
        launch_item.weight = hold_weight_reg;
        launch_item.acc    = '0;
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            hold_first_reg  <= s_tuser;
            hold_rank_reg   <= s_tdata[RANK_W-1:0];
            hold_weight_reg <= s_tdata[RANK_W+WEIGHT_W-1:RANK_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_SWEEP;
            sweep_cnt_reg   <= '0;
            epoch_reg       <= '0;
            gap_reg         <= 1'b0;
            outstanding_reg <= '0;
            inflight_reg    <= '0;
            hold_valid_reg  <= 1'b0;
        end else begin
            gap_reg         <= launch;
            outstanding_reg <= outstanding_reg + OCNT_W'(launch) - OCNT_W'(m_accept);
            inflight_reg    <= inflight_reg + OCNT_W'(launch)
                             - OCNT_W'(chain_valid[LEVELS]);
            if (s_accept) begin
                hold_valid_reg <= 1'b1;
            end else if (launch) begin
                hold_valid_reg <= 1'b0;
            end
            if (launch && hold_first_reg) begin
                epoch_reg <= epoch_reg + EPOCH_W'(1);
            end
            unique case (state_reg)
                ST_SWEEP: begin
                    sweep_cnt_reg <= sweep_cnt_reg + LEVELS'(1);
                    if (sweep_cnt_reg == {LEVELS{1'b1}}) begin
                        state_reg <= ST_RUN;
                        epoch_reg <= '0;
                    end
                end
                ST_RUN: begin
                    if (hold_valid_reg && hold_first_reg && (epoch_reg == EPOCH_MAX)) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (inflight_reg == '0) begin
                        state_reg     <= ST_SWEEP;
                        sweep_cnt_reg <= '0;
                    end
                end
                default: begin
                    state_reg <= ST_SWEEP;
                end
            endcase
        end
    end

    assign chain_valid[0] = launch;
    assign chain_r1[0]    = launch_r1;
    assign chain_item[0]  = launch_item;

    for (genvar l = 0; l < LEVELS; l++) begin : g_level
        drwps_cell #(
            .LEVELS (LEVELS),
            .LEVEL  (l)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .sweep_en   (state_reg == ST_SWEEP),
            .sweep_addr (sweep_cnt_reg),
            .in_valid   (chain_valid[l]),
            .in_r1      (chain_r1[l]),
            .in_item    (chain_item[l]),
            .out_valid  (chain_valid[l+1]),
            .out_r1     (chain_r1[l+1]),
            .out_item   (chain_item[l+1])
        );
    end

    drwps_ofifo u_ofifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (chain_valid[LEVELS]),
        .push_data  (chain_item[LEVELS].acc),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata)
    );

    // Back-to-back launches would read a node before its update is written.
    a_launch_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        launch |=> !launch)
        else $error("items launched in adjacent cycles");

    a_sweep_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> (inflight_reg == '0))
        else $error("clearing pass with items in the level row");

    a_count_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (inflight_reg <= outstanding_reg) && (outstanding_reg <= OCNT_W'(OFIFO_DEPTH)))
        else $error("item counters out of range");

    a_row_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_valid[LEVELS] |-> (inflight_reg != '0))
        else $error("result leaves the row with no item in flight");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for dyadic_rank_weighted_prefix_sum_top: a queued stream driver,
// a checking monitor and a dyadic-tree predictor kept in step with every accepted transfer.
// Depends on drwps_pkg and the block's RTL.
module testbench;
    import drwps_pkg::*;

    localparam int LEVELS     = 10;
    localparam int NODE_COUNT = 2 << LEVELS;
    localparam int TOP_RANK   = 1 << LEVELS;
    localparam int PAD_W      = IN_TDATA_W - RANK_W - WEIGHT_W;
    localparam int RANDOM_ITEMS   = 850;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 400;

    typedef struct {
        logic                first;
        logic [RANK_W-1:0]   rank;
        logic [WEIGHT_W-1:0] weight;
        bit                  wait_drain;
    } rank_item_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    rank_item_t pending_items[$];
    logic [SUM_W-1:0] expected_sums[$];
    logic [SUM_W-1:0] tree_node[0:NODE_COUNT-1];

    rank_item_t cur_item;
    rank_item_t next_item;
    int unsigned send_gap = 0;
    int unsigned items_sent = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    int unsigned results_seen = 0;
    int unsigned holds_done = 0;
    int unsigned idle_cycles = 0;
    int unsigned error_count = 0;
    logic [SUM_W-1:0] want_sum;

    dyadic_rank_weighted_prefix_sum_top #(.LEVELS(LEVELS)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // rank[10:0], weight[42:11]
        .s_tuser  (s_tuser),   // first
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // partial_sum[47:0]
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Tree model: query the covering nodes below rank, then add weight on every level.
    function automatic logic [SUM_W-1:0] predict_partial_sum(input logic first,
                                                             input logic [RANK_W-1:0] rank_in,
                                                             input logic [WEIGHT_W-1:0] weight);
        int unsigned below;
        int unsigned q;
        int unsigned base;
        logic [SUM_W-1:0] total;
        logic [SUM_W-1:0] wext;
        if (first) begin
            for (int i = 0; i < NODE_COUNT; i++) tree_node[i] = '0;
        end
        if (rank_in == 0) below = 0;
        else if (rank_in > TOP_RANK) below = TOP_RANK - 1;
        else below = rank_in - 1;
        wext = {{(SUM_W-WEIGHT_W){weight[WEIGHT_W-1]}}, weight};
        total = '0;
        base = 0;
        for (int l = 0; l < LEVELS; l++) begin
            q = below >> l;
            if (q[0]) total = total + tree_node[base + q - 1];
            base = base + (1 << (LEVELS - l));
        end
        base = 0;
        for (int l = 0; l < LEVELS; l++) begin
            tree_node[base + (below >> l)] = tree_node[base + (below >> l)] + wext;
            base = base + (1 << (LEVELS - l));
        end
        return total;
    endfunction

    // Mostly short pauses, a few long ones; none at all in a quiet stretch.
    function automatic int unsigned pick_pause(input bit quiet);
        int unsigned p;
        p = $urandom_range(0, 99);
        if (quiet || p < 55) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    task automatic add_item(input logic first, input logic [RANK_W-1:0] rank,
                            input logic [WEIGHT_W-1:0] weight, input bit wait_drain);
        rank_item_t it;
        it.first = first;
        it.rank = rank;
        it.weight = weight;
        it.wait_drain = wait_drain;
        pending_items.push_back(it);
    endtask

    function automatic logic [RANK_W-1:0] random_rank(input int unsigned span);
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 4) return '0;
        if (p < 8) return RANK_W'($urandom_range(TOP_RANK + 1, (1 << RANK_W) - 1));
        return RANK_W'($urandom_range(1, span));
    endfunction

    function automatic logic [WEIGHT_W-1:0] random_weight();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 5) return 32'h8000_0000;
        if (p < 10) return 32'h7FFF_FFFF;
        if (p < 15) return $urandom_range(0, 1) ? $urandom_range(0, 255)
                                                : -$urandom_range(1, 256);
        return $urandom;
    endfunction

    // Sets are mostly short so that many set starts occur; some are long, over narrow or
    // wide rank windows so that ranks repeat and cover the whole tree.
    task automatic fill_random_sets();
        int unsigned made;
        int unsigned len;
        int unsigned span;
        int unsigned p;
        made = 0;
        while (made < RANDOM_ITEMS) begin
            p = $urandom_range(0, 99);
            if (p < 65) len = 1;
            else if (p < 90) len = $urandom_range(2, 6);
            else len = $urandom_range(7, 20);
            case ($urandom_range(0, 2))
                0: span = 8;
                1: span = 64;
                default: span = TOP_RANK;
            endcase
            for (int i = 0; i < len; i++) begin
                // now and then a set runs on without a start flag
                add_item(i == 0 && $urandom_range(0, 19) != 0, random_rank(span),
                         random_weight(), made == RANDOM_ITEMS / 2 && i == 0);
                made++;
            end
        end
    endtask

    initial begin
        // extremes, saturation of rank zero and of ranks above the top, set clears
        add_item(1'b0, 11'd1,    32'h7FFF_FFFF, 1'b0);
        add_item(1'b0, 11'd1024, 32'h8000_0000, 1'b0);
        add_item(1'b0, 11'd0,    32'h0000_0005, 1'b0);
        add_item(1'b0, 11'd2047, 32'hFFFF_FFFF, 1'b0);
        add_item(1'b0, 11'd1025, 32'h0000_0001, 1'b0);
        add_item(1'b0, 11'd512,  32'h0001_0000, 1'b0);
        add_item(1'b0, 11'd513,  32'hFFFF_0000, 1'b0);
        add_item(1'b0, 11'd2,    32'h0000_0003, 1'b0);
        add_item(1'b0, 11'h555,  32'h5555_5555, 1'b0);
        add_item(1'b0, 11'h2AA,  32'hAAAA_AAAA, 1'b0);
        add_item(1'b1, 11'd1024, 32'h0000_0001, 1'b0);
        add_item(1'b0, 11'd1023, 32'h0000_0002, 1'b0);
        add_item(1'b0, 11'd3,    32'h8000_0000, 1'b0);
        add_item(1'b0, 11'd1024, 32'h7FFF_FFFF, 1'b0);
        add_item(1'b0, 11'd1024, 32'h0000_0000, 1'b0);
        add_item(1'b0, 11'd0,    32'h8000_0000, 1'b0);
        add_item(1'b1, 11'd5,    32'h1234_5678, 1'b0);
        add_item(1'b1, 11'd6,    32'h0000_0009, 1'b0);
        add_item(1'b0, 11'd7,    32'hFFFF_FFF0, 1'b0);
        add_item(1'b0, 11'd2047, 32'h0000_0100, 1'b0);
        add_item(1'b1, 11'd0,    32'h0000_0001, 1'b0);
        add_item(1'b0, 11'd1,    32'h0000_0002, 1'b0);
        // first random item waits for every result of the directed part
        add_item(1'b1, 11'd2,    32'h0000_0004, 1'b1);
        fill_random_sets();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_tvalid || expected_sums.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Driver: predict on each accepted transfer, then offer the next item after its gap.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_sums.push_back(predict_partial_sum(cur_item.first, cur_item.rank,
                                                            cur_item.weight));
                items_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() != 0 &&
                             !(pending_items[0].wait_drain && expected_sums.size() != 0)) begin
                    next_item = pending_items.pop_front();
                    cur_item <= next_item;
                    s_tdata <= {{PAD_W{1'b0}}, next_item.weight, next_item.rank};
                    s_tuser <= next_item.first;
                    s_tvalid <= 1'b1;
                    send_gap <= pick_pause((items_sent / 100) % 3 == 1);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result against the oldest prediction and pace m_tready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_sums.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, m_tdata);
                    error_count++;
                end else begin
                    want_sum = expected_sums.pop_front();
                    if (m_tdata !== want_sum) begin
                        $display("%0t: partial_sum mismatch, expected %h, actual %h",
                                 $time, want_sum, m_tdata);
                        error_count++;
                    end
                end
            end
            // two long hold-offs let the result queue fill and back up the input
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else if ((holds_done == 0 && results_seen >= 30) ||
                         (holds_done == 1 && results_seen >= 400)) begin
                holds_done++;
                hold_left <= LONG_HOLD;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall_left <= pick_pause((results_seen / 128) % 3 == 2);
            end
        end
    end

    // Watchdog: long runs without any transfer mean the block has hung.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
